/* rtl/core/concatenated_segment_locator_core_assert.svh */
// Assertion macros for the concatenated segment locator core.
// Included by the RTL files that assert; no other dependencies.
`ifndef CONCATENATED_SEGMENT_LOCATOR_CORE_ASSERT_SVH
`define CONCATENATED_SEGMENT_LOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk while rst_n is high.
`define CSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define CSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CSL_ASSERT(lbl, prop, msg)
`define CSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/csl_pkg.sv */
// Shared types and constants for the concatenated segment locator core.
// No dependencies.
package csl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SEP_W   = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_DW   = 128;
  localparam int unsigned OUT_DW  = 176;

  localparam logic [SEP_W-1:0] SEP_RESET = 16'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_POS    = 2'd1,
    MODE_IDX    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SKIPPED   = 2'd3
  } status_t;

  // One table row as stored in the entry RAM.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] start;
  } entry_t;

endpackage

/* rtl/core/csl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module csl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/concatenated_segment_locator_core.sv */
// Concatenated segment locator: entry table with a running stream total and a
// binary search by position. Depends on csl_pkg, csl_ram and the assert header.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tuser: mode; tdata: id, length, position, index
//  out_     out  out_tvalid/tready    tuser: status; tdata: index, id, start, len, total
//  cfg_     in   cfg_we               cfg_wdata: separator length
//
// One transaction at a time. Append goes through S_APP, an index query through
// S_LOAD and a clear straight to S_DONE; a position query searches in S_CMP,
// one search step per cycle through the single read port of the entry RAM.
// in_tready is low from accept until the result moves into the output
// register; a stalled output holds the next result back. Reset empties the
// table at once; the RAM itself is never cleared.
`include "concatenated_segment_locator_core_assert.svh"

module concatenated_segment_locator_core
  import csl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SEP_W-1:0]  cfg_wdata,   // separator_length
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,    // entry_id, entry_length, position, index
  input  logic [MODE_W-1:0] in_tuser,    // mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,   // seq_index, seq_id, seq_start, seq_length,
                                         // total_length
  output logic [STAT_W-1:0] out_tuser    // status
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_APP  = 5'b00010,
    S_CMP  = 5'b00100,
    S_LOAD = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] lo, input logic [AW-1:0] hi);
    logic [AW:0] span;
    span = {1'b0, hi} - {1'b0, lo} + (AW+1)'(1);
    return lo + span[AW:1];
  endfunction

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [POS_W-1:0]    total_r, total_nxt;
  logic [SEP_W-1:0]    sep_r;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [AW-1:0]       res_idx_r, res_idx_nxt;
  entry_t              res_ent_r, res_ent_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DW-1:0]   out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0]   out_tuser_r, out_tuser_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  logic                in_accept;
  logic [ID_W-1:0]     in_id;
  logic [LEN_W-1:0]    in_len;
  logic [POS_W-1:0]    in_pos;
  logic [IDX_W-1:0]    in_idx;
  logic [WW-1:0]       in_idx_w, cnt_w, res_idx_w;
  logic [AW-1:0]       cnt_m1;
  logic [POS_W:0]      app_sum;
  logic                ge;
  logic [AW-1:0]       lo_c, hi_c, mid_c;

  assign in_id    = in_tdata[31:0];
  assign in_len   = in_tdata[63:32];
  assign in_pos   = in_tdata[111:64];
  assign in_idx   = in_tdata[121:112];
  assign in_idx_w = WW'(in_idx);
  assign cnt_w    = WW'(cnt_r);
  assign cnt_m1   = AW'(cnt_r - CW'(1));
  assign res_idx_w = WW'(res_idx_r);
  assign app_sum  = {1'b0, total_r} + (POS_W+1)'(len_r) + (POS_W+1)'(sep_r);

  // search step: keep the upper half when the probed start is at or below the position
  assign ge    = (ram_rdata.start <= pos_r);
  assign lo_c  = ge ? mid_r : lo_r;
  assign hi_c  = ge ? hi_r : (mid_r - AW'(1));
  assign mid_c = mid_of(lo_c, hi_c);

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign ram_wdata = '{id: id_r, len: len_r, start: total_r};

  csl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    id_nxt         = id_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ent_nxt    = res_ent_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_raddr      = lo_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          id_nxt         = in_id;
          len_nxt        = in_len;
          pos_nxt        = in_pos;
          res_status_nxt = ST_NOT_FOUND;
          res_idx_nxt    = '0;
          res_ent_nxt    = '0;
          unique case (mode_t'(in_tuser))
            MODE_APPEND: begin
              state_nxt = S_APP;
            end
            MODE_POS: begin
              if (cnt_r == '0 || in_pos >= total_r) begin
                state_nxt = S_DONE;
              end else begin
                lo_nxt = '0;
                hi_nxt = cnt_m1;
                if (cnt_m1 == '0) begin
                  ram_raddr = '0;
                  state_nxt = S_LOAD;
                end else begin
                  ram_raddr = mid_of('0, cnt_m1);
                  mid_nxt   = mid_of('0, cnt_m1);
                  state_nxt = S_CMP;
                end
              end
            end
            MODE_IDX: begin
              if (in_idx_w < cnt_w) begin
                ram_raddr = in_idx_w[AW-1:0];
                lo_nxt    = in_idx_w[AW-1:0];
                state_nxt = S_LOAD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            MODE_CLEAR: begin
              cnt_nxt        = '0;
              total_nxt      = '0;
              res_status_nxt = ST_OK;
              state_nxt      = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_APP: begin
        if (len_r == '0) begin
          res_status_nxt = ST_SKIPPED;
        end else if (cnt_r >= CW'(MAX_ENTRIES) || app_sum[POS_W]) begin
          res_status_nxt = ST_FULL;
        end else begin
          ram_we         = 1'b1;
          total_nxt      = app_sum[POS_W-1:0];
          cnt_nxt        = cnt_r + CW'(1);
          res_status_nxt = ST_OK;
          res_idx_nxt    = cnt_r[AW-1:0];
          res_ent_nxt    = ram_wdata;
        end
        state_nxt = S_DONE;
      end
      S_CMP: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        if (lo_c < hi_c) begin
          ram_raddr = mid_c;
          mid_nxt   = mid_c;
        end else begin
          ram_raddr = lo_c;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        res_status_nxt = ST_OK;
        res_idx_nxt    = lo_r;
        res_ent_nxt    = ram_rdata;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {6'b0, total_r, res_ent_r.len, res_ent_r.start, res_ent_r.id,
                            res_idx_w[IDX_W-1:0]};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      total_r      <= '0;
      sep_r        <= SEP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      total_r      <= total_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    len_r        <= len_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ent_r    <= res_ent_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `CSL_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_ENTRIES), "entry count above table size")
  `CSL_ASSERT(a_mid_in_range, (state_r == S_CMP) |-> (mid_r > lo_r && mid_r <= hi_r), "search probe outside bounds")
  `CSL_ASSERT(a_busy_after_accept, in_accept |=> !in_tready, "ready again right after accept")
  `CSL_ASSERT(a_total_nonzero, (cnt_r != '0) |-> (total_r != '0), "entries present with zero total")

endmodule
